>>> rtl/film_grain_pixel_top_assert.svh
// Assertion macros for the film grain pixel RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FILM_GRAIN_PIXEL_TOP_ASSERT_SVH
`define FILM_GRAIN_PIXEL_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FGP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FGP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fgp_pkg.sv
// Package for the film grain pixel block: payload types, register codes,
// fixed-point constants and small arithmetic helpers. No dependencies.
package fgp_pkg;

  localparam int COORD_W    = 12;
  localparam int CELL_W     = 9;
  localparam int COLOR_W    = 16;
  localparam int SEED_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_DIM         = 4096;
  localparam int COLOR_FRAC_BITS = 12;
  localparam int COLOR_ONE       = 1 << COLOR_FRAC_BITS;
  localparam int INV_W           = COLOR_FRAC_BITS + 1;

  localparam int DIV_STEP = 4;

  localparam int HASH_W = 32;
  localparam logic [HASH_W-1:0] HASH_MUL_X = 32'd374761393;
  localparam logic [HASH_W-1:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [HASH_W-1:0] HASH_MUL_S = 32'd362437;
  localparam logic [HASH_W-1:0] HASH_ADD   = 32'd2246822519;
  localparam logic [HASH_W-1:0] HASH_MIX   = 32'd1274126177;

  localparam int NOISE_W = 24;
  localparam logic [NOISE_W:0] NOISE_MID = 25'd16777215;

  localparam int LUMA_SUM_W = 33;
  localparam logic [COLOR_W-1:0] LUMA_R = 16'd13933;
  localparam logic [COLOR_W-1:0] LUMA_G = 16'd46871;
  localparam logic [COLOR_W-1:0] LUMA_B = 16'd4732;
  localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = 33'd32768;
  localparam int LUMA_SHIFT = 16;

  localparam int SCALE_W = 17;
  localparam logic [SCALE_W-1:0] SCALE_BASE = 17'd22938;
  localparam logic [COLOR_W-1:0] SCALE_SPAN = 16'd42598;
  localparam logic [SCALE_W-1:0] SCALE_FULL = 17'd65536;
  localparam int LPROD_W = COLOR_W + INV_W;

  localparam int NA_W    = NOISE_W + COLOR_W;
  localparam int LO_W    = NOISE_W + SCALE_W;
  localparam int HI_W    = COLOR_W + SCALE_W;
  localparam int TOT_W   = HI_W + NOISE_W + 1;
  localparam int MAG_SHIFT = 40;
  localparam int MAG_W   = 17;

  localparam logic [COLOR_W-1:0]   AMOUNT_RST = 16'd246;
  localparam logic [CELL_W-1:0]    CELL_RST   = 9'd1;
  localparam logic [SEED_W-1:0]    SEED_RST   = 32'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAIN_AMOUNT   = 4'd0,
    CFG_CELL_SIZE      = 4'd1,
    CFG_NOISE_SEED     = 4'd2,
    CFG_LUMA_WEIGHT_ON = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
  } result_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CELL_W-1:0]   rem;
    logic [DIV_STEP-1:0] q;
  } div_res_t;

  // Several restoring division steps; the remainder stays below the divisor.
  function automatic div_res_t div_steps(input logic [CELL_W-1:0] rem,
                                         input logic [DIV_STEP-1:0] bits,
                                         input logic [CELL_W-1:0] dvs);
    logic [CELL_W:0]     r;
    logic [DIV_STEP-1:0] q;
    div_res_t            res;
    r = {1'b0, rem};
    q = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      r = {r[CELL_W-1:0], bits[i]};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[i] = 1'b1;
      end
    end
    res.rem = r[CELL_W-1:0];
    res.q   = q;
    return res;
  endfunction

  function automatic logic [COLOR_W-1:0] add_grain(input logic [COLOR_W-1:0] chan,
                                                   input logic neg,
                                                   input logic [MAG_W-1:0] mag);
    logic [MAG_W:0]     sum;
    logic [MAG_W-1:0]   diff;
    logic [COLOR_W-1:0] res;
    sum  = {2'b00, chan} + {1'b0, mag};
    diff = {1'b0, chan} - mag;
    if (neg) begin
      res = (mag >= {1'b0, chan}) ? '0 : diff[COLOR_W-1:0];
    end else begin
      res = (sum[MAG_W:COLOR_W] != '0) ? '1 : sum[COLOR_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/film_grain_pixel_top.sv
// Film grain pixel top level: eleven-stage pipeline with configuration registers.
// Depends on fgp_pkg and film_grain_pixel_top_assert.svh.
//
// Pixels enter on the pix channel (pix_valid, pix_stall, pix_data) and leave on
// the grain channel (grain_valid, grain_stall, grain_data). A transaction
// completes when valid is high and stall is low. One pixel may enter in every
// cycle while grain_stall is low; the sustained rate is then one pixel per clock.
// Each pixel passes through eleven register stages: three of cell division
// (four quotient bits a stage), hash, luminance weighting, the grain multiply
// split in two partial products, and a saturating output register.
// Every stage has its own valid bit. When grain_stall holds the output, the
// stages in front still close up empty slots, so pix_stall rises only once
// the whole pipeline is full; nothing is dropped or repeated.
// Registers are written through cfg_valid, cfg_ready, cfg_index and cfg_data;
// cfg_ready is always high and unknown indexes are ignored. The user must change
// registers only while the pipeline is empty; the block itself does not enforce it.
// Synchronous reset empties the pipeline and loads the register defaults:
// amount 246, cell size 1, seed 1, luminance weighting on.
module film_grain_pixel_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pix_valid,
  output logic                             pix_stall,
  input  fgp_pkg::pixel_t                  pix_data,
  output logic                             grain_valid,
  input  logic                             grain_stall,
  output fgp_pkg::result_t                 grain_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fgp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fgp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  `include "film_grain_pixel_top_assert.svh"

  localparam int NS   = 11;
  localparam int CW   = fgp_pkg::COORD_W;
  localparam int KW   = fgp_pkg::CELL_W;
  localparam int COLW = fgp_pkg::COLOR_W;
  localparam int HW   = fgp_pkg::HASH_W;
  localparam int DS   = fgp_pkg::DIV_STEP;
  localparam int NW   = fgp_pkg::NOISE_W;
  localparam int SW   = fgp_pkg::SCALE_W;
  localparam int IW   = fgp_pkg::INV_W;
  localparam int LSW  = fgp_pkg::LUMA_SUM_W;
  localparam int FB   = fgp_pkg::COLOR_FRAC_BITS;
  localparam int TW   = fgp_pkg::TOT_W;
  localparam int MW   = fgp_pkg::MAG_W;
  localparam int MSH  = fgp_pkg::MAG_SHIFT;
  localparam int LUMA_SHIFT_L = fgp_pkg::LUMA_SHIFT;

  logic [COLW-1:0] grain_amount;
  logic [KW-1:0]   cell_size;
  logic [HW-1:0]   noise_seed;
  logic            luma_weight_on;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grain_amount   <= fgp_pkg::AMOUNT_RST;
      cell_size      <= fgp_pkg::CELL_RST;
      noise_seed     <= fgp_pkg::SEED_RST;
      luma_weight_on <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fgp_pkg::CFG_GRAIN_AMOUNT:   grain_amount   <= cfg_data[COLW-1:0];
        fgp_pkg::CFG_CELL_SIZE:      cell_size      <= cfg_data[KW-1:0];
        fgp_pkg::CFG_NOISE_SEED:     noise_seed     <= cfg_data[HW-1:0];
        fgp_pkg::CFG_LUMA_WEIGHT_ON: luma_weight_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [NS-1:0] v;
  logic [NS-1:0] ld;
  logic [NS-1:0] vin;

  always_comb begin
    ld[NS-1] = !v[NS-1] || !grain_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign vin         = {v[NS-2:0], pix_valid};
  assign pix_stall   = !ld[0];
  assign grain_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (ld[k]) begin
          v[k] <= vin[k];
        end
      end
    end
  end

  fgp_pkg::rgb_t col [NS-1];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      col[0] <= '{red: pix_data.red_in, green: pix_data.green_in, blue: pix_data.blue_in};
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (ld[k]) begin
        col[k] <= col[k-1];
      end
    end
  end

  logic [KW-1:0] dvs;
  logic [CW-1:0] xc;
  logic [CW-1:0] yc;
  fgp_pkg::div_res_t dx0, dy0, dx1, dy1, dx2, dy2;

  logic [KW-1:0]      s0_remx, s0_remy, s1_remx, s1_remy;
  logic [DS-1:0]      s0_qx, s0_qy;
  logic [2*DS-1:0]    s1_qx, s1_qy;
  logic [CW-DS-1:0]   s0_xlo, s0_ylo;
  logic [DS-1:0]      s1_xlo, s1_ylo;
  logic [CW-1:0]      s2_cx, s2_cy;
  logic [31:0]        s0_lr, s0_lg, s0_lb;
  logic [IW-1:0]      s1_inv;
  logic [fgp_pkg::LPROD_W-1:0] s2_lprod;
  logic [HW-1:0]      s3_hx, s3_hy, s3_hs;
  logic [SW-1:0]      s3_scale, s4_scale, s5_scale, s6_scale, s7_scale;
  logic [HW-1:0]      s4_h, s5_h;
  logic [NW-1:0]      s6_nmag;
  logic               s6_neg, s7_neg, s8_neg, s9_neg;
  logic [fgp_pkg::NA_W-1:0] s7_na;
  logic [fgp_pkg::LO_W-1:0] s8_lo;
  logic [fgp_pkg::HI_W-1:0] s8_hi;
  logic [MW-1:0]      s9_mag;

  logic [LSW-1:0]     luma_sum;
  logic [LSW-LUMA_SHIFT_L-1:0] luma;
  logic [IW-1:0]      luma_c;
  logic [fgp_pkg::LPROD_W-1:0] lprod_r;
  logic [HW-1:0]      h0, h1, h3;
  logic [NW:0]        m2;
  logic               neg6;
  logic [NW:0]        nmag6;
  logic [TW-1:0]      tot;

  always_comb begin
    dvs = (cell_size == '0) ? KW'(1) : cell_size;
    xc  = (32'(pix_data.pixel_x) >= fgp_pkg::MAX_DIM) ? CW'(fgp_pkg::MAX_DIM - 1)
                                                      : pix_data.pixel_x;
    yc  = (32'(pix_data.pixel_y) >= fgp_pkg::MAX_DIM) ? CW'(fgp_pkg::MAX_DIM - 1)
                                                      : pix_data.pixel_y;
    dx0 = fgp_pkg::div_steps('0, xc[CW-1 -: DS], dvs);
    dy0 = fgp_pkg::div_steps('0, yc[CW-1 -: DS], dvs);
    dx1 = fgp_pkg::div_steps(s0_remx, s0_xlo[CW-DS-1 -: DS], dvs);
    dy1 = fgp_pkg::div_steps(s0_remy, s0_ylo[CW-DS-1 -: DS], dvs);
    dx2 = fgp_pkg::div_steps(s1_remx, s1_xlo, dvs);
    dy2 = fgp_pkg::div_steps(s1_remy, s1_ylo, dvs);

    luma_sum = LSW'(s0_lr) + LSW'(s0_lg) + LSW'(s0_lb) + fgp_pkg::LUMA_ROUND;
    luma     = luma_sum[LSW-1:LUMA_SHIFT_L];
    luma_c   = (luma > (LSW-LUMA_SHIFT_L)'(fgp_pkg::COLOR_ONE)) ? IW'(fgp_pkg::COLOR_ONE)
                                                                : luma[IW-1:0];
    lprod_r  = s2_lprod + fgp_pkg::LPROD_W'(fgp_pkg::COLOR_ONE / 2);

    h0 = s3_hx + s3_hy + s3_hs + fgp_pkg::HASH_ADD;
    h1 = h0 ^ (h0 >> 13);
    h3 = s5_h ^ (s5_h >> 16);
    m2 = {h3[NW-1:0], 1'b0};
    neg6  = m2 < fgp_pkg::NOISE_MID;
    nmag6 = neg6 ? (fgp_pkg::NOISE_MID - m2) : (m2 - fgp_pkg::NOISE_MID);

    tot = {1'b0, s8_hi, {NW{1'b0}}} + TW'(s8_lo) + (TW'(1) << (MSH - 1));
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_remx <= dx0.rem;
      s0_remy <= dy0.rem;
      s0_qx   <= dx0.q;
      s0_qy   <= dy0.q;
      s0_xlo  <= xc[CW-DS-1:0];
      s0_ylo  <= yc[CW-DS-1:0];
      s0_lr   <= 32'(pix_data.red_in * fgp_pkg::LUMA_R);
      s0_lg   <= 32'(pix_data.green_in * fgp_pkg::LUMA_G);
      s0_lb   <= 32'(pix_data.blue_in * fgp_pkg::LUMA_B);
    end
    if (ld[1]) begin
      s1_remx <= dx1.rem;
      s1_remy <= dy1.rem;
      s1_qx   <= {s0_qx, dx1.q};
      s1_qy   <= {s0_qy, dy1.q};
      s1_xlo  <= s0_xlo[DS-1:0];
      s1_ylo  <= s0_ylo[DS-1:0];
      s1_inv  <= IW'(fgp_pkg::COLOR_ONE) - luma_c;
    end
    if (ld[2]) begin
      s2_cx    <= {s1_qx, dx2.q};
      s2_cy    <= {s1_qy, dy2.q};
      s2_lprod <= fgp_pkg::LPROD_W'(fgp_pkg::SCALE_SPAN * s1_inv);
    end
    if (ld[3]) begin
      s3_hx    <= HW'(HW'(s2_cx) * fgp_pkg::HASH_MUL_X);
      s3_hy    <= HW'(HW'(s2_cy) * fgp_pkg::HASH_MUL_Y);
      s3_hs    <= HW'(noise_seed * fgp_pkg::HASH_MUL_S);
      s3_scale <= luma_weight_on ? (fgp_pkg::SCALE_BASE + SW'(lprod_r >> FB))
                                 : fgp_pkg::SCALE_FULL;
    end
    if (ld[4]) begin
      s4_h     <= h1;
      s4_scale <= s3_scale;
    end
    if (ld[5]) begin
      s5_h     <= HW'(s4_h * fgp_pkg::HASH_MIX);
      s5_scale <= s4_scale;
    end
    if (ld[6]) begin
      s6_nmag  <= nmag6[NW-1:0];
      s6_neg   <= neg6;
      s6_scale <= s5_scale;
    end
    if (ld[7]) begin
      s7_na    <= fgp_pkg::NA_W'(s6_nmag * grain_amount);
      s7_neg   <= s6_neg;
      s7_scale <= s6_scale;
    end
    if (ld[8]) begin
      s8_lo  <= fgp_pkg::LO_W'(s7_na[NW-1:0] * s7_scale);
      s8_hi  <= fgp_pkg::HI_W'(s7_na[fgp_pkg::NA_W-1:NW] * s7_scale);
      s8_neg <= s7_neg;
    end
    if (ld[9]) begin
      s9_mag <= tot[MSH +: MW];
      s9_neg <= s8_neg;
    end
    if (ld[10]) begin
      grain_data.red_out   <= fgp_pkg::add_grain(col[9].red, s9_neg, s9_mag);
      grain_data.green_out <= fgp_pkg::add_grain(col[9].green, s9_neg, s9_mag);
      grain_data.blue_out  <= fgp_pkg::add_grain(col[9].blue, s9_neg, s9_mag);
    end
  end

  `FGP_ASSERT_NOW(a_div_rem, v[1], (s1_remx < dvs) && (s1_remy < dvs), "division remainder not below cell size")
  `FGP_ASSERT_NEXT(a_scale_off, ld[4] && v[3] && !luma_weight_on, s4_scale == fgp_pkg::SCALE_FULL, "scale not full with weighting off")
  `FGP_ASSERT_NEXT(a_neg_down, ld[10] && v[9] && s9_neg, grain_data.red_out <= $past(col[9].red), "negative grain raised red")
  `FGP_ASSERT_NEXT(a_full_hold, v[9] && v[10] && grain_stall, v[9], "stage lost while output stalled")
  `FGP_ASSERT_NOW(a_bubble_take, !v[0], !pix_stall, "input stalled with an empty first stage")

endmodule
